>>> rtl/core/dcb_pkg.sv
// shared types and constants for the descriptor chain builder
package dcb_pkg;

  localparam int ADDR_W = 32;
  localparam int LEN_W  = 20;
  localparam int SIZE_W = 13;
  localparam int SIZES_W = 2 * SIZE_W;

  // control word flag bits
  localparam logic [31:0] FLAG_OWN   = 32'h8000_0000;
  localparam logic [31:0] FLAG_FIRST = 32'h0000_0008;
  localparam logic [31:0] FLAG_LAST  = 32'h0000_0004;
  localparam logic [31:0] FLAG_NOINT = 32'h0000_0002;

  // depth of the queue between front and back
  localparam int QUEUE_DEPTH = 2;

  typedef struct packed {
    logic [ADDR_W-1:0] buffer_address;
    logic [LEN_W-1:0]  transfer_length;
  } req_t;

  typedef struct packed {
    logic [31:0]        control_word;
    logic [SIZES_W-1:0] buffer_sizes;
    logic [ADDR_W-1:0]  first_buffer_address;
    logic [ADDR_W-1:0]  second_buffer_address;
    logic               final_descriptor;
  } desc_t;

endpackage

>>> rtl/core/dcb_front.sv
// front stage: takes requests, drops empty ones and clamps the length
module dcb_front import dcb_pkg::*; #(
  parameter int CHUNK_BYTES     = 8192,
  parameter int MAX_DESCRIPTORS = 64
) (
  input  logic clk,
  input  logic rst,
  input  logic req_valid,
  output logic req_stall,
  input  req_t req,
  output logic push,
  output req_t push_req,
  input  logic full
);

  localparam logic [LEN_W-1:0] LEN_CAP = LEN_W'(MAX_DESCRIPTORS * CHUNK_BYTES);

  logic held_valid;
  req_t held;
  req_t clamped;

  always_comb begin
    clamped = req;
    if (req.transfer_length > LEN_CAP) begin
      clamped.transfer_length = LEN_CAP;
    end
  end

  assign push      = held_valid;
  assign push_req  = held;
  assign req_stall = held_valid && full;

  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
    end else if (!req_stall) begin
      // zero length requests produce nothing and never enter the queue
      held_valid <= req_valid && (req.transfer_length != '0);
    end
    if (req_valid && !req_stall) begin
      held <= clamped;
    end
  end

endmodule

>>> rtl/core/dcb_queue.sv
// small request queue between the front and back stages
module dcb_queue import dcb_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  req_t push_req,
  output logic full,
  input  logic pop,
  output req_t head,
  output logic head_valid
);

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(QUEUE_DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(QUEUE_DEPTH);

  req_t             mem [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_push;
  logic             do_pop;

  assign full       = (count == FULL_CNT);
  assign head_valid = (count != '0);
  assign head       = mem[rd_ptr];
  assign do_push    = push && !full;
  assign do_pop     = pop && head_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == LAST_PTR) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == LAST_PTR) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
    if (do_push) begin
      mem[wr_ptr] <= push_req;
    end
  end

endmodule

>>> rtl/core/dcb_back.sv
// back stage: walks one request chunk by chunk and emits descriptors
module dcb_back import dcb_pkg::*; #(
  parameter int CHUNK_BYTES = 8192
) (
  input  logic  clk,
  input  logic  rst,
  input  logic  head_valid,
  input  req_t  head,
  output logic  pop,
  output logic  desc_valid,
  input  logic  desc_stall,
  output desc_t desc
);

  localparam logic [LEN_W-1:0]  CHUNK_LEN = LEN_W'(CHUNK_BYTES);
  localparam logic [LEN_W-1:0]  HALF_LEN  = LEN_W'(CHUNK_BYTES / 2);
  localparam logic [SIZE_W-1:0] HALF_SIZE = SIZE_W'(CHUNK_BYTES / 2);
  localparam logic [SIZE_W-1:0] REST_SIZE = SIZE_W'(CHUNK_BYTES - CHUNK_BYTES / 2);
  localparam logic [ADDR_W-1:0] CHUNK_ADDR = ADDR_W'(CHUNK_BYTES);
  localparam logic [ADDR_W-1:0] HALF_ADDR  = ADDR_W'(CHUNK_BYTES / 2);

  logic              busy;
  logic              first;
  logic [ADDR_W-1:0] addr;
  logic [LEN_W-1:0]  remaining;

  logic              emit;
  logic              is_short;
  logic              is_last;
  logic [LEN_W-1:0]  tail_len;
  logic [SIZE_W-1:0] size1;
  logic [SIZE_W-1:0] size2;
  desc_t             cur;

  assign pop  = !busy && head_valid;
  assign emit = busy && (!desc_valid || !desc_stall);

  always_comb begin
    is_short = (remaining <= HALF_LEN);
    is_last  = (remaining <= CHUNK_LEN);
    tail_len = remaining - HALF_LEN;
    if (is_short) begin
      size1 = remaining[SIZE_W-1:0];
      size2 = '0;
    end else begin
      size1 = HALF_SIZE;
      size2 = is_last ? tail_len[SIZE_W-1:0] : REST_SIZE;
    end
    cur.control_word = FLAG_OWN | (first ? FLAG_FIRST : '0)
                     | (is_last ? FLAG_LAST : FLAG_NOINT);
    cur.buffer_sizes          = {size2, size1};
    cur.first_buffer_address  = addr;
    cur.second_buffer_address = is_short ? '0 : addr + HALF_ADDR;
    cur.final_descriptor      = is_last;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy       <= 1'b0;
      desc_valid <= 1'b0;
    end else begin
      if (pop) begin
        busy <= 1'b1;
      end else if (emit && is_last) begin
        busy <= 1'b0;
      end
      if (emit) begin
        desc_valid <= 1'b1;
      end else if (!desc_stall) begin
        desc_valid <= 1'b0;
      end
    end
    if (pop) begin
      addr      <= head.buffer_address;
      remaining <= head.transfer_length;
      first     <= 1'b1;
    end else if (emit) begin
      addr      <= addr + CHUNK_ADDR;
      remaining <= remaining - CHUNK_LEN;
      first     <= 1'b0;
    end
    if (emit) begin
      desc <= cur;
    end
  end

endmodule

>>> rtl/core/dma_descriptor_chain_builder.sv
// top level of the dma descriptor chain builder
//
// each req transaction (buffer address, byte length) is cut into chunks of
// CHUNK_BYTES and one desc transaction is produced per chunk, in address
// order; each chunk is split into a first buffer of up to half a chunk and a
// second buffer with the rest, the second address being zero when that buffer
// is empty. a zero length produces nothing, and a length beyond
// MAX_DESCRIPTORS chunks is cut to MAX_DESCRIPTORS full chunks. the front
// stage holds one request and clamps it, a two-entry queue decouples it from
// the back stage, and the back stage emits one descriptor per cycle while
// desc_stall is low, from its chunk walker into an output register. the back
// stage loads a request from the queue and then walks it, taking the next
// request only once the last descriptor of the current one is emitted. reset
// clears the valid flags, the queue pointers and count and the busy flag;
// the data registers are not reset.
module dma_descriptor_chain_builder import dcb_pkg::*; #(
  parameter int CHUNK_BYTES     = 8192,
  parameter int MAX_DESCRIPTORS = 64
) (
  input  logic  clk,
  input  logic  rst,
  input  logic  req_valid,
  output logic  req_stall,
  input  req_t  req,
  output logic  desc_valid,
  input  logic  desc_stall,
  output desc_t desc
);

  // front to queue
  logic push;
  req_t push_req;
  logic full;

  // queue to back
  logic pop;
  req_t head;
  logic head_valid;

  dcb_front #(
    .CHUNK_BYTES     (CHUNK_BYTES),
    .MAX_DESCRIPTORS (MAX_DESCRIPTORS)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .push      (push),
    .push_req  (push_req),
    .full      (full)
  );

  // requests wait here while the back stage walks an earlier one
  dcb_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_req   (push_req),
    .full       (full),
    .pop        (pop),
    .head       (head),
    .head_valid (head_valid)
  );

  // chunk walker and output register
  dcb_back #(
    .CHUNK_BYTES (CHUNK_BYTES)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .head_valid (head_valid),
    .head       (head),
    .pop        (pop),
    .desc_valid (desc_valid),
    .desc_stall (desc_stall),
    .desc       (desc)
  );

endmodule
